@@ hdl/srst_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed range statistics tree package
// Field widths and opcode values shared by the statistics tree design.
// ----------------------------------------------------------------------------
package srst_pkg;

  // Fixed widths of the beat fields.
  localparam int INDEX_BITS     = 10;
  localparam int IN_VALUE_BITS  = 32;
  localparam int OUT_VALUE_BITS = 32;

  // Opcodes of an input beat.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

@@ hdl/signed_range_statistics_tree_top.sv @@
// Write beat: S_IDLE accepts it and writes the leaf, then S_WUP rewrites each parent up to the root.
// Query beat: S_IDLE accepts it, S_QWALK folds the covering nodes level by level (skipped
// for an empty range), then S_QOUT loads the result register; one beat is in work at a time.
// The rate is set by the node memory's two read ports and the shared merge unit.
// After reset a clearing pass rewrites all 2*ELEMENT_COUNT nodes with the empty record;
// in_ready stays low until it is done.
// ----------------------------------------------------------------------------
// Signed range statistics tree, top level
// Segment tree over signed elements held in one node memory. Writes update
// the leaf-to-root path; queries fold the covering nodes into one result.
// ----------------------------------------------------------------------------
module signed_range_statistics_tree_top
  import srst_pkg::*;
#(
  parameter int ELEMENT_COUNT = 1024,
  parameter int VALUE_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [INDEX_BITS-1:0]            in_element_index,
  input  logic signed [IN_VALUE_BITS-1:0]  in_element_value,
  input  logic [INDEX_BITS-1:0]            in_range_left,
  input  logic [INDEX_BITS-1:0]            in_range_right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_empty_range,
  output logic                             out_has_zero,
  output logic                             out_has_negative,
  output logic signed [OUT_VALUE_BITS-1:0] out_max_negative,
  output logic                             out_has_positive,
  output logic signed [OUT_VALUE_BITS-1:0] out_min_positive,
  output logic signed [OUT_VALUE_BITS-1:0] out_range_max,
  output logic signed [OUT_VALUE_BITS-1:0] out_range_min
);

  localparam int NODE_COUNT = 2 * ELEMENT_COUNT;
  localparam int NB         = $clog2(NODE_COUNT);
  localparam int HB         = NB + 1;
  localparam int NODE_W     = 4 * VALUE_BITS + 3;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WUP   = 3'd2;
  localparam logic [2:0] S_QWALK = 3'd3;
  localparam logic [2:0] S_QOUT  = 3'd4;

  typedef struct packed {
    logic                         zero;
    logic                         has_neg;
    logic signed [VALUE_BITS-1:0] neg_max;
    logic                         has_pos;
    logic signed [VALUE_BITS-1:0] pos_min;
    logic signed [VALUE_BITS-1:0] mx;
    logic signed [VALUE_BITS-1:0] mn;
  } node_t;

  // Sign-extend a stored value and keep the low result bits.
  function automatic logic [OUT_VALUE_BITS-1:0] to_out(input logic signed [VALUE_BITS-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[OUT_VALUE_BITS-1:0];
  endfunction

  // Node memory and its registered read ports.
  node_t mem [0:NODE_COUNT-1];
  node_t rd_a_r;
  node_t rd_b_r;

  logic [2:0]    state_r, state_nxt;
  logic [NB-1:0] clr_r, clr_nxt;
  logic [NB-1:0] p_r, p_nxt;
  logic [HB-1:0] lo_r, lo_nxt;
  logic [HB-1:0] hi_r, hi_nxt;
  logic          use_a_r, use_a_nxt;
  logic          use_b_r, use_b_nxt;
  node_t         acc_r, acc_nxt;
  logic          empty_r, empty_nxt;
  logic          out_valid_r;
  logic          out_load;

  logic          we;
  logic [NB-1:0] wa;
  node_t         wd;
  logic [NB-1:0] ra;
  logic [NB-1:0] rb;

  node_t ident;
  node_t leaf_rec;
  node_t a_in;
  node_t b_in;
  logic [NODE_W-1:0] m0_y;
  logic [NODE_W-1:0] m1_y;

  logic signed [VALUE_BITS-1:0] val_in;
  logic [63:0]   val_wide;
  logic          idx_ok;
  logic [NB-1:0] leaf;
  logic [NB-1:0] parent;
  logic [31:0]   l_sat;
  logic [31:0]   r_sat;
  logic [HB-1:0] hi_m1;

  // Empty-node record, the identity of the merge.
  always_comb begin
    ident         = '0;
    ident.mx      = {1'b1, {(VALUE_BITS-1){1'b0}}};
    ident.mn      = {1'b0, {(VALUE_BITS-1){1'b1}}};
  end

  // Incoming value at the stored width, and its leaf record.
  assign val_wide = {32'b0, in_element_value};
  assign val_in   = $signed(val_wide[VALUE_BITS-1:0]);

  always_comb begin
    leaf_rec         = '0;
    leaf_rec.zero    = (val_in == '0);
    leaf_rec.has_neg = val_in[VALUE_BITS-1];
    leaf_rec.neg_max = val_in[VALUE_BITS-1] ? val_in : '0;
    leaf_rec.has_pos = !val_in[VALUE_BITS-1] && (val_in != '0);
    leaf_rec.pos_min = leaf_rec.has_pos ? val_in : '0;
    leaf_rec.mx      = val_in;
    leaf_rec.mn      = val_in;
  end

  assign idx_ok = (32'(in_element_index) < 32'(ELEMENT_COUNT));
  assign leaf   = NB'(ELEMENT_COUNT) + NB'(in_element_index);
  assign parent = p_r >> 1;
  assign hi_m1  = hi_r - HB'(1);

  // Range bounds saturated to the last element.
  assign l_sat = (32'(in_range_left) > 32'(ELEMENT_COUNT - 1)) ?
                 32'(ELEMENT_COUNT - 1) : 32'(in_range_left);
  assign r_sat = (32'(in_range_right) > 32'(ELEMENT_COUNT - 1)) ?
                 32'(ELEMENT_COUNT - 1) : 32'(in_range_right);

  // Shared merge unit: the first stage folds the accumulator with port A,
  // the second adds port B during a range walk.
  assign a_in = ((state_r == S_WUP) || use_a_r) ? rd_a_r : ident;
  assign b_in = use_b_r ? rd_b_r : ident;

  srst_merge #(
    .VALUE_BITS (VALUE_BITS)
  ) u_merge_a (
    .node_a (acc_r),
    .node_b (a_in),
    .node_y (m0_y)
  );

  srst_merge #(
    .VALUE_BITS (VALUE_BITS)
  ) u_merge_b (
    .node_a (m0_y),
    .node_b (b_in),
    .node_y (m1_y)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    p_nxt     = p_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    use_a_nxt = 1'b0;
    use_b_nxt = 1'b0;
    acc_nxt   = acc_r;
    empty_nxt = empty_r;
    out_load  = 1'b0;
    we        = 1'b0;
    wa        = clr_r;
    wd        = ident;
    ra        = p_r;
    rb        = p_r;
    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        clr_nxt = clr_r + NB'(1);
        if (clr_r == NB'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_WRITE) begin
            if (idx_ok) begin
              we        = 1'b1;
              wa        = leaf;
              wd        = leaf_rec;
              acc_nxt   = leaf_rec;
              p_nxt     = leaf;
              ra        = leaf ^ NB'(1);
              state_nxt = S_WUP;
            end
          end else begin
            lo_nxt    = HB'(l_sat + 32'(ELEMENT_COUNT));
            hi_nxt    = HB'(r_sat + 32'(ELEMENT_COUNT) + 32'd1);
            empty_nxt = (l_sat > r_sat);
            acc_nxt   = ident;
            state_nxt = (l_sat > r_sat) ? S_QOUT : S_QWALK;
          end
        end
      end
      S_WUP: begin
        // Port A holds the sibling of the node written last cycle.
        we      = 1'b1;
        wa      = parent;
        wd      = node_t'(m0_y);
        acc_nxt = node_t'(m0_y);
        p_nxt   = parent;
        ra      = parent ^ NB'(1);
        if (parent == NB'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_QWALK: begin
        acc_nxt = node_t'(m1_y);
        if (lo_r < hi_r) begin
          ra        = lo_r[NB-1:0];
          rb        = hi_m1[NB-1:0];
          use_a_nxt = lo_r[0];
          use_b_nxt = hi_r[0];
          lo_nxt    = (lo_r + HB'(lo_r[0])) >> 1;
          hi_nxt    = hi_r >> 1;
        end else begin
          state_nxt = S_QOUT;
        end
      end
      S_QOUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Node memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      use_a_r <= 1'b0;
      use_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      use_a_r <= use_a_nxt;
      use_b_r <= use_b_nxt;
    end
  end

  // Walk position and accumulator.
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    acc_r   <= acc_nxt;
    empty_r <= empty_nxt;
  end

  // Result register; holds a beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_empty_range  <= empty_r;
      out_has_zero     <= !empty_r && acc_r.zero;
      out_has_negative <= !empty_r && acc_r.has_neg;
      out_max_negative <= (!empty_r && acc_r.has_neg) ?
                          $signed(to_out(acc_r.neg_max)) : '0;
      out_has_positive <= !empty_r && acc_r.has_pos;
      out_min_positive <= (!empty_r && acc_r.has_pos) ?
                          $signed(to_out(acc_r.pos_min)) : '0;
      out_range_max    <= empty_r ? '0 : $signed(to_out(acc_r.mx));
      out_range_min    <= empty_r ? '0 : $signed(to_out(acc_r.mn));
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/srst_merge.sv @@
// ----------------------------------------------------------------------------
// Tree node merge unit
// Combines two node records: zero flag, largest negative value, smallest
// positive value, maximum and minimum. Purely combinational.
// ----------------------------------------------------------------------------
module srst_merge #(
  parameter int VALUE_BITS = 32
) (
  input  logic [4*VALUE_BITS+2:0] node_a,
  input  logic [4*VALUE_BITS+2:0] node_b,
  output logic [4*VALUE_BITS+2:0] node_y
);

  typedef struct packed {
    logic                         zero;
    logic                         has_neg;
    logic signed [VALUE_BITS-1:0] neg_max;
    logic                         has_pos;
    logic signed [VALUE_BITS-1:0] pos_min;
    logic signed [VALUE_BITS-1:0] mx;
    logic signed [VALUE_BITS-1:0] mn;
  } node_t;

  node_t na;
  node_t nb;
  node_t ny;

  assign na     = node_t'(node_a);
  assign nb     = node_t'(node_b);
  assign node_y = ny;

  // Each statistic is folded independently; absent values stay zero.
  always_comb begin
    ny.zero    = na.zero | nb.zero;
    ny.has_neg = na.has_neg | nb.has_neg;
    if (na.has_neg && nb.has_neg) begin
      ny.neg_max = (na.neg_max > nb.neg_max) ? na.neg_max : nb.neg_max;
    end else if (na.has_neg) begin
      ny.neg_max = na.neg_max;
    end else if (nb.has_neg) begin
      ny.neg_max = nb.neg_max;
    end else begin
      ny.neg_max = '0;
    end
    ny.has_pos = na.has_pos | nb.has_pos;
    if (na.has_pos && nb.has_pos) begin
      ny.pos_min = (na.pos_min < nb.pos_min) ? na.pos_min : nb.pos_min;
    end else if (na.has_pos) begin
      ny.pos_min = na.pos_min;
    end else if (nb.has_pos) begin
      ny.pos_min = nb.pos_min;
    end else begin
      ny.pos_min = '0;
    end
    ny.mx = (na.mx > nb.mx) ? na.mx : nb.mx;
    ny.mn = (na.mn < nb.mn) ? na.mn : nb.mn;
  end

endmodule
